// File: src/fsfa_pkg.sv
// Shared types, constants and a helper function of the slot allocator.
`default_nettype none
package fsfa_pkg;

  localparam int SLOTS  = 1024;
  localparam int SLOT_W = 10;
  localparam int CNT_W  = 11;
  localparam int WORD_W = 32;
  localparam int BIT_W  = 5;
  localparam int WORDS  = SLOTS / WORD_W;
  localparam int WIDX_W = SLOT_W - BIT_W;
  localparam int STAT_W = 2;

  localparam logic [STAT_W-1:0] ST_GRANTED = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL    = 2'd1;
  localparam logic [STAT_W-1:0] ST_RANGE   = 2'd2;

  localparam logic REQ_PARK    = 1'b0;
  localparam logic REQ_RELEASE = 1'b1;

  localparam logic [1:0] JOB_REL   = 2'd0;
  localparam logic [1:0] JOB_RANGE = 2'd1;
  localparam logic [1:0] JOB_PARK  = 2'd2;

  typedef struct packed {
    logic [1:0]        kind;
    logic [SLOT_W-1:0] slot;
    logic [SLOT_W-1:0] last;   // highest active slot, valid for parks only
  } fsfa_job_t;

  typedef struct packed {
    logic      vld;
    fsfa_job_t job;
  } fsfa_q_t;

  // Index of the lowest set bit; zero when none is set.
  function automatic logic [BIT_W-1:0] lsb_idx(input logic [WORD_W-1:0] v);
    logic [BIT_W-1:0] idx;
    idx = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (v[i]) idx = BIT_W'(i);
    end
    return idx;
  endfunction

endpackage
`default_nettype wire

// File: src/circular_first_free_slot_allocator.sv
// Top level of the circular first-free slot allocator.
// An out-of-range park is answered from the idle state without a memory read; a release and
// a park each read a map word and then check it, and a park may read further words. The
// engine takes the next item only once it is back in idle, as the read-then-check loop on
// the single port of the occupancy memory serialises the work.
// Reset (synchronous, active low) frees every slot at once through per-word valid bits,
// so no clearing pass is needed, and sets the active count to 1024.
`default_nettype none
module circular_first_free_slot_allocator
  import fsfa_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  output logic                   full,
  input  wire logic              in_req_type,
  input  wire logic [SLOT_W-1:0] in_slot,
  output logic                   empty,
  input  wire logic              pop,
  output logic [SLOT_W-1:0]      out_granted_slot,
  output logic [STAT_W-1:0]      out_status,
  input  wire logic              cfg_wr_en,
  input  wire logic [CNT_W-1:0]  cfg_wr_data
);

  // The front end holds the active count and classifies each request against it as
  // a release, an out-of-range park or a park to search, then queues it. A full queue
  // stalls the input side without holding up the engine.
  fsfa_q_t q_head;
  logic    q_pop;

  fsfa_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .push        (push),
    .full        (full),
    .in_req_type (in_req_type),
    .in_slot     (in_slot),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .q_head      (q_head),
    .q_pop       (q_pop)
  );

  // The back end keeps the map as 32 words of 32 bits with a summary bit per word that
  // marks a word with a free slot. A search checks the preferred word from the preferred
  // slot upwards, then the next word onwards with a free slot, then wraps round to the
  // words below, and finally the lower part of the preferred word. Each result transaction
  // waits in an output register until it is popped.
  fsfa_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_head           (q_head),
    .q_pop            (q_pop),
    .empty            (empty),
    .pop              (pop),
    .out_granted_slot (out_granted_slot),
    .out_status       (out_status)
  );

endmodule
`default_nettype wire

// File: src/fsfa_front.sv
// Front end: takes requests, classifies them and queues them for the search engine.
`default_nettype none
module fsfa_front
  import fsfa_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  output logic                   full,
  input  wire logic              in_req_type,
  input  wire logic [SLOT_W-1:0] in_slot,
  input  wire logic              cfg_wr_en,
  input  wire logic [CNT_W-1:0]  cfg_wr_data,
  output fsfa_q_t                q_head,
  input  wire logic              q_pop
);

  localparam int QDEPTH = 4;
  localparam int QP_W   = 2;

  logic [CNT_W-1:0] active_r;
  logic [CNT_W-1:0] n_eff;
  fsfa_job_t        job_in;
  fsfa_job_t        q_mem_r [QDEPTH];
  logic [QP_W-1:0]  wp_r, rp_r;
  logic [QP_W:0]    cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  always_comb begin
    n_eff = (active_r > CNT_W'(SLOTS)) ? CNT_W'(SLOTS) : active_r;
    job_in.slot = in_slot;
    job_in.last = SLOT_W'(n_eff - CNT_W'(1));
    if (in_req_type == REQ_RELEASE) begin
      job_in.kind = JOB_REL;
    end else if ({1'b0, in_slot} >= n_eff) begin
      job_in.kind = JOB_RANGE;
    end else begin
      job_in.kind = JOB_PARK;
    end
  end

  assign full    = (cnt_r == (QP_W+1)'(QDEPTH));
  assign do_push = push && !full;
  assign do_pop  = q_pop && (cnt_r != '0);

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) cnt_nxt = cnt_r + (QP_W+1)'(1);
    if (!do_push && do_pop) cnt_nxt = cnt_r - (QP_W+1)'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= CNT_W'(SLOTS);
      wp_r     <= '0;
      rp_r     <= '0;
      cnt_r    <= '0;
    end else begin
      if (cfg_wr_en) active_r <= cfg_wr_data;
      if (do_push) wp_r <= wp_r + QP_W'(1);
      if (do_pop)  rp_r <= rp_r + QP_W'(1);
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) q_mem_r[wp_r] <= job_in;
  end

  assign q_head.vld = (cnt_r != '0);
  assign q_head.job = q_mem_r[rp_r];

endmodule
`default_nettype wire

// File: src/fsfa_back.sv
// Back end: occupancy map, word-by-word free-slot search and the result register.
`default_nettype none
module fsfa_back
  import fsfa_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire fsfa_q_t            q_head,
  output logic                    q_pop,
  output logic                    empty,
  input  wire logic               pop,
  output logic [SLOT_W-1:0]       out_granted_slot,
  output logic [STAT_W-1:0]       out_status
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RD   = 2'd1;
  localparam logic [1:0] S_CHK  = 2'd2;

  localparam logic [2:0] PH_REL = 3'd0;
  localparam logic [2:0] PH_A   = 3'd1;
  localparam logic [2:0] PH_B   = 3'd2;
  localparam logic [2:0] PH_C   = 3'd3;
  localparam logic [2:0] PH_D   = 3'd4;

  localparam logic [WORD_W-1:0] ONES = '1;
  localparam logic [WORD_W-1:0] ONES_BUT_LSB = {{(WORD_W-1){1'b1}}, 1'b0};

  logic [1:0]        state_r, state_nxt;
  logic [2:0]        phase_r, phase_nxt;
  logic [SLOT_W-1:0] slot_r, slot_nxt;
  logic [SLOT_W-1:0] last_r, last_nxt;
  logic [WIDX_W-1:0] cur_w_r, cur_w_nxt;
  logic [WORDS-1:0]  hasfree_r;
  logic [WORDS-1:0]  row_vld_r;
  logic [WORD_W-1:0] mem_r [WORDS];
  logic [WORD_W-1:0] rd_data_r;
  logic              rd_vld_r;

  logic              out_vld_r, out_vld_nxt;
  logic [SLOT_W-1:0] out_g_r, out_g_nxt;
  logic [STAT_W-1:0] out_s_r, out_s_nxt;

  logic              out_free;
  logic [WORD_W-1:0] word, free_bits, act_mask, m;
  logic              hit;
  logic [BIT_W-1:0]  hit_bit;
  logic [WIDX_W-1:0] w0, lastw;
  logic [BIT_W-1:0]  s_lo, lastb;
  logic [WORDS-1:0]  cand_b, cand_c;
  logic              wr_en;
  logic [WORD_W-1:0] wr_data;

  assign out_free = !out_vld_r || pop;
  assign w0    = slot_r[SLOT_W-1:BIT_W];
  assign s_lo  = slot_r[BIT_W-1:0];
  assign lastw = last_r[SLOT_W-1:BIT_W];
  assign lastb = last_r[BIT_W-1:0];

  always_comb begin
    word      = rd_vld_r ? rd_data_r : '0;
    free_bits = ~word;
    if (cur_w_r < lastw) act_mask = ONES;
    else                 act_mask = ~(ONES_BUT_LSB << lastb);
    unique case (phase_r)
      PH_A:    m = free_bits & (ONES << s_lo) & act_mask;
      PH_B:    m = free_bits & act_mask;
      PH_C:    m = free_bits;
      PH_D:    m = free_bits & ~(ONES << s_lo);
      default: m = '0;
    endcase
    hit     = |m;
    hit_bit = lsb_idx(m);
    cand_b  = hasfree_r & (ONES_BUT_LSB << w0) & ~(ONES_BUT_LSB << lastw);
    cand_c  = hasfree_r & ~(ONES << w0);
  end

  always_comb begin
    state_nxt   = state_r;
    phase_nxt   = phase_r;
    slot_nxt    = slot_r;
    last_nxt    = last_r;
    cur_w_nxt   = cur_w_r;
    q_pop       = 1'b0;
    wr_en       = 1'b0;
    wr_data     = word;
    out_vld_nxt = out_vld_r && !pop;
    out_g_nxt   = out_g_r;
    out_s_nxt   = out_s_r;
    unique case (state_r)
      S_IDLE: begin
        if (q_head.vld && (q_head.job.kind == JOB_REL || out_free)) begin
          q_pop     = 1'b1;
          slot_nxt  = q_head.job.slot;
          last_nxt  = q_head.job.last;
          cur_w_nxt = q_head.job.slot[SLOT_W-1:BIT_W];
          unique case (q_head.job.kind)
            JOB_REL: begin
              phase_nxt = PH_REL;
              state_nxt = S_RD;
            end
            JOB_PARK: begin
              phase_nxt = PH_A;
              state_nxt = S_RD;
            end
            default: begin
              out_vld_nxt = 1'b1;
              out_g_nxt   = '0;
              out_s_nxt   = ST_RANGE;
            end
          endcase
        end
      end
      S_RD: state_nxt = S_CHK;
      S_CHK: begin
        if (phase_r == PH_REL) begin
          wr_en     = 1'b1;
          wr_data   = word & ~(WORD_W'(1) << s_lo);
          state_nxt = S_IDLE;
        end else if (hit) begin
          wr_en       = 1'b1;
          wr_data     = word | (WORD_W'(1) << hit_bit);
          out_vld_nxt = 1'b1;
          out_g_nxt   = {cur_w_r, hit_bit};
          out_s_nxt   = ST_GRANTED;
          state_nxt   = S_IDLE;
        end else if (phase_r == PH_D) begin
          out_vld_nxt = 1'b1;
          out_g_nxt   = '0;
          out_s_nxt   = ST_FULL;
          state_nxt   = S_IDLE;
        end else begin
          state_nxt = S_RD;
          if (phase_r == PH_A && (|cand_b)) begin
            phase_nxt = PH_B;
            cur_w_nxt = lsb_idx(cand_b);
          end else if ((phase_r == PH_A || phase_r == PH_B) && (|cand_c)) begin
            phase_nxt = PH_C;
            cur_w_nxt = lsb_idx(cand_c);
          end else begin
            phase_nxt = PH_D;
            cur_w_nxt = w0;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      phase_r   <= PH_REL;
      out_vld_r <= 1'b0;
      hasfree_r <= '1;
      row_vld_r <= '0;
    end else begin
      state_r   <= state_nxt;
      phase_r   <= phase_nxt;
      out_vld_r <= out_vld_nxt;
      if (wr_en) begin
        hasfree_r[cur_w_r] <= ~(&wr_data);
        row_vld_r[cur_w_r] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    slot_r  <= slot_nxt;
    last_r  <= last_nxt;
    cur_w_r <= cur_w_nxt;
    out_g_r <= out_g_nxt;
    out_s_r <= out_s_nxt;
    if (state_r == S_RD) begin
      rd_data_r <= mem_r[cur_w_r];
      rd_vld_r  <= row_vld_r[cur_w_r];
    end
    if (wr_en) mem_r[cur_w_r] <= wr_data;
  end

  assign empty            = !out_vld_r;
  assign out_granted_slot = out_g_r;
  assign out_status       = out_s_r;

endmodule
`default_nettype wire
